// ----- rtl/core/tcsg_pkg.sv -----
package tcsg_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_CEILING_COLOR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_COLOR    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXTURE_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXTURE_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 3'd4;

  localparam logic [12:0] TEXTURE_WIDTH_RST  = 13'd64;
  localparam logic [12:0] TEXTURE_HEIGHT_RST = 13'd64;
  localparam logic [12:0] IMAGE_WIDTH_RST    = 13'd1024;

  localparam logic OP_SETUP = 1'b0;
  localparam logic OP_ROW   = 1'b1;

  localparam logic [1:0] SIDE_X = 2'd0;
  localparam logic [1:0] SIDE_Y = 2'd1;

  localparam logic [7:0] ALPHA = 8'd180;

  // quotient bits of (texture_height << 16) / length
  localparam int DIV_STEPS = 29;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    KIND_CEILING = 2'd0,
    KIND_WALL    = 2'd1,
    KIND_FLOOR   = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL
  } ctl_state_t;

  typedef struct packed {
    logic               op;
    logic [11:0]        column;
    logic signed [15:0] wall_start;
    logic signed [15:0] wall_end;
    logic [1:0]         side;
    logic [15:0]        hit_fraction;
    logic               dir_x_positive;
    logic               dir_y_negative;
  } in_item_t;

  typedef struct packed {
    logic [8:0]  row;
    kind_t       kind;
    logic [1:0]  texture_select;
    logic [23:0] pixel_index;
    logic [23:0] texel_index;
    logic [31:0] color;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic setup_load;
    logic div_step;
    logic mul_load;
    logic row_emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic len_pos;
    logic row_last;
  } ctl_sts_t;

endpackage

// ----- rtl/core/tcsg_ctrl.sv -----
module tcsg_ctrl import tcsg_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_op,
  output logic     in_ready,
  input  logic     out_ready,
  output logic     out_valid,
  input  ctl_sts_t sts,
  output ctl_cmd_t cmd
);

  ctl_state_t           state_r, state_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic                 active_r, active_nxt;
  logic                 out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      div_cnt_r   <= '0;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_cnt_r   <= div_cnt_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    div_cnt_nxt   = div_cnt_r;
    active_nxt    = active_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    in_ready      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = !out_valid_r || out_ready;
        if (in_valid && in_ready) begin
          if (in_op == OP_SETUP) begin
            cmd.setup_load = 1'b1;
            active_nxt     = 1'b1;
            div_cnt_nxt    = '0;
            if (sts.len_pos) begin
              state_nxt = ST_DIV;
            end
          end else if (active_r) begin
            cmd.row_emit  = 1'b1;
            out_valid_nxt = 1'b1;
            if (sts.row_last) begin
              active_nxt = 1'b0;
            end
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_nxt  = div_cnt_r + 1'b1;
        if (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul_load = 1'b1;
        state_nxt    = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

  a_setup_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.setup_load && sts.len_pos) |=> (state_r == ST_DIV))
    else $error("non-empty wall setup did not start the divider");

  a_div_exits_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |=> (state_r == ST_DIV || state_r == ST_MUL))
    else $error("divider left without the step multiply");

  a_mul_single: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL) |=> (state_r == ST_IDLE))
    else $error("step multiply took more than one cycle");

  a_last_row_retires: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.row_emit && sts.row_last) |=> (!active_r && out_valid_r))
    else $error("last row did not close the column");

endmodule

// ----- rtl/core/tcsg_datapath.sv -----
module tcsg_datapath import tcsg_pkg::*; #(
  parameter int SCREEN_ROWS = 512
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  in_item_t              in_item,
  input  ctl_cmd_t              cmd,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output ctl_sts_t              sts,
  output out_item_t             out_item
);

  localparam int CW        = $clog2(SCREEN_ROWS);
  localparam int PIX_W     = CW + 14;
  localparam int HALF_ROWS = SCREEN_ROWS / 2;

  logic [23:0] ceiling_color_r;
  logic [23:0] floor_color_r;
  logic [12:0] texture_width_r;
  logic [12:0] texture_height_r;
  logic [12:0] image_width_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ceiling_color_r  <= '0;
      floor_color_r    <= '0;
      texture_width_r  <= TEXTURE_WIDTH_RST;
      texture_height_r <= TEXTURE_HEIGHT_RST;
      image_width_r    <= IMAGE_WIDTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CEILING_COLOR:  ceiling_color_r  <= cfg_data[23:0];
        CFG_FLOOR_COLOR:    floor_color_r    <= cfg_data[23:0];
        CFG_TEXTURE_WIDTH:  texture_width_r  <= cfg_data[12:0];
        CFG_TEXTURE_HEIGHT: texture_height_r <= cfg_data[12:0];
        CFG_IMAGE_WIDTH:    image_width_r    <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  logic [28:0]        hit_prod;
  logic [12:0]        tx;
  logic [12:0]        tx_m;
  logic               mirror;
  logic signed [16:0] len;
  logic               len_pos;

  assign hit_prod = 29'(in_item.hit_fraction) * 29'(texture_width_r);
  assign tx       = hit_prod[28:16];
  assign mirror   = (in_item.side == SIDE_X && in_item.dir_x_positive) ||
                    (in_item.side == SIDE_Y && in_item.dir_y_negative);
  assign tx_m     = mirror ? (texture_width_r - tx - 13'd1) : tx;
  assign len      = 17'(in_item.wall_end) - 17'(in_item.wall_start);
  assign len_pos  = !len[16] && (|len[15:0]);

  logic [11:0]        column_r;
  logic signed [15:0] span_start_r;
  logic signed [15:0] span_end_r;
  logic [1:0]         side_r;
  logic [11:0]        texel_column_r;
  logic [15:0]        half_len_r;
  logic [15:0]        divisor_r;
  logic [15:0]        rem_r;
  logic [28:0]        quo_r;
  logic [28:0]        row_step_r;
  logic signed [47:0] texel_pos_r;
  logic [CW-1:0]      row_cnt_r;
  out_item_t          out_r;

  logic [16:0]        div_shift;
  logic [17:0]        div_diff;
  logic               div_neg;

  assign div_shift = {rem_r, quo_r[28]};
  assign div_diff  = {1'b0, div_shift} - {2'b00, divisor_r};
  assign div_neg   = div_diff[17];

  logic signed [17:0] mul_a;
  logic signed [29:0] mul_b;
  logic signed [47:0] mul_prod;

  assign mul_a    = signed'({2'b00, half_len_r}) - signed'(18'(HALF_ROWS));
  assign mul_b    = signed'({1'b0, quo_r});
  assign mul_prod = mul_a * mul_b;

  logic signed [16:0] r_s;
  logic signed [16:0] st_s;
  logic signed [16:0] en_s;
  logic [PIX_W-1:0]   pidx;
  logic [PIX_W-1:0]   plim;
  logic               in_frame;
  logic [12:0]        ty;
  logic [12:0]        ty_m;
  logic [25:0]        tex;
  logic               row_last;
  out_item_t          row_res;

  assign r_s      = signed'(17'(row_cnt_r));
  assign st_s     = 17'(span_start_r);
  assign en_s     = 17'(span_end_r);
  assign pidx     = PIX_W'(row_cnt_r) * PIX_W'(image_width_r) + PIX_W'(column_r);
  assign plim     = PIX_W'(SCREEN_ROWS) * PIX_W'(image_width_r);
  assign in_frame = pidx < plim;
  assign ty       = texel_pos_r[28:16] + 13'(texel_pos_r[47] && (|texel_pos_r[15:0]));
  assign ty_m     = ty & (texture_height_r - 13'd1);
  assign tex      = 26'(ty_m) * 26'(texture_width_r) + 26'(texel_column_r);
  assign row_last = row_cnt_r == CW'(SCREEN_ROWS - 1);

  always_comb begin
    row_res      = '0;
    row_res.row  = 9'(row_cnt_r);
    row_res.last = row_last;
    row_res.kind = KIND_NONE;
    if (st_s < en_s && r_s >= st_s && r_s < en_s) begin
      row_res.kind           = KIND_WALL;
      row_res.texture_select = side_r;
      row_res.texel_index    = tex[23:0];
    end else if (r_s > en_s) begin
      row_res.kind  = KIND_FLOOR;
      row_res.color = {floor_color_r, ALPHA};
    end else if (r_s < st_s) begin
      row_res.kind  = KIND_CEILING;
      row_res.color = {ceiling_color_r, ALPHA};
    end
    if (!in_frame) begin
      row_res.kind           = KIND_NONE;
      row_res.texture_select = '0;
      row_res.texel_index    = '0;
      row_res.color          = '0;
    end
    if (row_res.kind != KIND_NONE) begin
      row_res.pixel_index = 24'(pidx);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.setup_load) begin
      column_r       <= in_item.column;
      span_start_r   <= in_item.wall_start;
      span_end_r     <= in_item.wall_end;
      side_r         <= in_item.side;
      texel_column_r <= tx_m[11:0];
      half_len_r     <= len[16:1];
      divisor_r      <= len[15:0];
      rem_r          <= '0;
      quo_r          <= {texture_height_r, 16'd0};
      row_step_r     <= '0;
      texel_pos_r    <= '0;
      row_cnt_r      <= '0;
    end
    if (cmd.div_step) begin
      rem_r <= div_neg ? div_shift[15:0] : div_diff[15:0];
      quo_r <= {quo_r[27:0], !div_neg};
    end
    if (cmd.mul_load) begin
      row_step_r  <= quo_r;
      texel_pos_r <= mul_prod;
    end
    if (cmd.row_emit) begin
      out_r       <= row_res;
      texel_pos_r <= texel_pos_r + signed'(48'(row_step_r));
      if (!row_last) begin
        row_cnt_r <= row_cnt_r + 1'b1;
      end
    end
  end

  assign sts.len_pos  = len_pos;
  assign sts.row_last = row_last;
  assign out_item     = out_r;

endmodule

// ----- rtl/core/textured_column_span_generator.sv -----
// channel   direction  handshake              payload
// in_       request    in_valid / in_ready    in_item   (in_item_t)
// out_      result     out_valid / out_ready  out_item  (out_item_t)
// cfg_      register   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Row request: result held in an output register; next request taken as it drains.
// Setup request, non-empty wall: the setup load, then the step divider, which produces the 29
// quotient bits one at a time, then the start-position multiply; empty wall: the setup load only.
// Reset synchronous on rst_n; no clearing pass. Input stalls while the output register
// holds an untaken result or the divider or the multiply runs. cfg_ready stays high.
module textured_column_span_generator import tcsg_pkg::*; #(
  parameter int SCREEN_ROWS = 512
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  assign cfg_ready = 1'b1;

  tcsg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_item.op),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  tcsg_datapath #(
    .SCREEN_ROWS (SCREEN_ROWS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sts       (sts),
    .out_item  (out_item)
  );

endmodule

// ----- verif/tb.sv -----
module tb;
  import tcsg_pkg::*;

  localparam int SCREEN_ROWS   = 512;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT   = 2000;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_FIRST = 3'd5;

  typedef struct packed {
    logic [23:0] ceil_rgb;
    logic [23:0] floor_rgb;
    logic [12:0] tex_w;
    logic [12:0] tex_h;
    logic [12:0] img_w;
  } look_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_item   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_item;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  look_t cur_look = '{ceil_rgb: 24'd0, floor_rgb: 24'd0, tex_w: TEXTURE_WIDTH_RST,
                      tex_h: TEXTURE_HEIGHT_RST, img_w: IMAGE_WIDTH_RST};

  logic [11:0] col_x;
  int          span_top;
  int          span_bot;
  logic [1:0]  col_side;
  logic [11:0] tcol;
  logic [31:0] tex_step;
  longint      tex_pos;
  int          rcount;
  bit          col_live;

  out_item_t rows_due[$];

  int  sent;
  int  ignored;
  int  setups;
  int  checked;
  int  fails;
  int  kind_seen[4];
  int  last_seen;
  int  idle_cycles;
  int  tx_mode;
  int  rx_mode;
  int  rx_cycles;
  int  rx_gap;
  bit  calm;
  bit  hold_request;

  textured_column_span_generator #(.SCREEN_ROWS(SCREEN_ROWS)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic int burst_len(int mode);
    if (calm || mode == 0) return 0;
    if ($urandom_range(0, (mode == 1) ? 11 : 3) != 0) return 0;
    return $urandom_range(1, 15);
  endfunction

  function automatic string describe(out_item_t r);
    return $sformatf("row %0d kind %0d sel %0d pixel %06h texel %06h colour %08h last %0b",
                     r.row, r.kind, r.texture_select, r.pixel_index, r.texel_index,
                     r.color, r.last);
  endfunction

  task automatic advance_column(input in_item_t it);
    out_item_t   res;
    logic [63:0] tx;
    logic [63:0] pidx;
    logic [12:0] wrap;
    longint      ty;
    int          len;
    bit          in_frame;
    if (it.op == OP_SETUP) begin
      col_x    = it.column;
      span_top = int'(it.wall_start);
      span_bot = int'(it.wall_end);
      col_side = it.side;
      tx = (64'(it.hit_fraction) * cur_look.tex_w) >> 16;
      if ((col_side == SIDE_X && it.dir_x_positive) || (col_side == SIDE_Y && it.dir_y_negative))
        tx = 64'(cur_look.tex_w) - tx - 64'd1;
      tcol = tx[11:0];
      len  = span_bot - span_top;
      if (len > 0) begin
        tex_step = 32'((longint'(64'(cur_look.tex_h)) << 16) / len);
        tex_pos  = longint'(len / 2 - SCREEN_ROWS / 2) * $signed({32'd0, tex_step});
      end else begin
        tex_step = '0;
        tex_pos  = 0;
      end
      rcount   = 0;
      col_live = 1'b1;
      setups++;
      sent++;
    end else if (!col_live) begin
      ignored++;
    end else begin
      sent++;
      res      = '0;
      res.kind = KIND_NONE;
      pidx     = 64'(rcount) * cur_look.img_w + col_x;
      in_frame = pidx < 64'(SCREEN_ROWS) * cur_look.img_w;
      if (span_top < span_bot && rcount >= span_top && rcount < span_bot) begin
        ty   = (tex_pos >= 0) ? (tex_pos >>> 16) : -((-tex_pos) >>> 16);
        wrap = cur_look.tex_h - 13'd1;
        res.kind           = KIND_WALL;
        res.texture_select = col_side;
        res.texel_index    = 24'((64'(ty[12:0] & wrap) * cur_look.tex_w) + tcol);
      end else if (rcount > span_bot) begin
        res.kind  = KIND_FLOOR;
        res.color = {cur_look.floor_rgb, ALPHA};
      end else if (rcount < span_top) begin
        res.kind  = KIND_CEILING;
        res.color = {cur_look.ceil_rgb, ALPHA};
      end
      if (!in_frame) begin
        res.kind           = KIND_NONE;
        res.texture_select = '0;
        res.texel_index    = '0;
        res.color          = '0;
      end
      if (res.kind != KIND_NONE) res.pixel_index = pidx[23:0];
      res.row  = rcount[8:0];
      res.last = (rcount == SCREEN_ROWS - 1);
      rows_due.push_back(res);
      tex_pos += $signed({32'd0, tex_step});
      if (rcount >= SCREEN_ROWS - 1) col_live = 1'b0;
      else rcount++;
    end
  endtask

  task automatic send_item(input in_item_t it);
    int gap;
    if ((sent + ignored) % 64 == 0) tx_mode = $urandom_range(0, 2);
    gap = burst_len(tx_mode);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    advance_column(it);
  endtask

  task automatic drain(input int settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (rows_due.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic apply_settings(input look_t look);
    logic [CFG_IDX_W-1:0]  idx[6];
    logic [CFG_DATA_W-1:0] val[6];
    drain(SETTLE_CYCLES);
    idx = '{CFG_CEILING_COLOR, CFG_FLOOR_COLOR, CFG_TEXTURE_WIDTH, CFG_TEXTURE_HEIGHT,
            CFG_IMAGE_WIDTH, CFG_UNUSED_FIRST + 3'($urandom_range(0, 2))};
    val = '{look.ceil_rgb, look.floor_rgb, {11'($urandom), look.tex_w},
            {11'($urandom), look.tex_h}, {11'($urandom), look.img_w}, 24'($urandom)};
    for (int i = 0; i < 6; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (!cfg_ready);
      case (idx[i])
        CFG_CEILING_COLOR:  cur_look.ceil_rgb  = val[i];
        CFG_FLOOR_COLOR:    cur_look.floor_rgb = val[i];
        CFG_TEXTURE_WIDTH:  cur_look.tex_w     = val[i][12:0];
        CFG_TEXTURE_HEIGHT: cur_look.tex_h     = val[i][12:0];
        CFG_IMAGE_WIDTH:    cur_look.img_w     = val[i][12:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic in_item_t setup_req(logic [11:0] x, logic signed [15:0] top,
                                         logic signed [15:0] bot, logic [1:0] sel,
                                         logic [15:0] frac, logic dxp, logic dyn);
    in_item_t it;
    it                = '0;
    it.op             = OP_SETUP;
    it.column         = x;
    it.wall_start     = top;
    it.wall_end       = bot;
    it.side           = sel;
    it.hit_fraction   = frac;
    it.dir_x_positive = dxp;
    it.dir_y_negative = dyn;
    return it;
  endfunction

  function automatic in_item_t row_req();
    in_item_t it;
    it = setup_req(12'($urandom), 16'($urandom), 16'($urandom), 2'($urandom),
                   16'($urandom), 1'($urandom), 1'($urandom));
    it.op = OP_ROW;
    return it;
  endfunction

  function automatic in_item_t random_setup();
    int top;
    int bot;
    logic [11:0] x;
    case ($urandom_range(0, 3))
      0:       x = 12'($urandom_range(0, 15));
      1:       x = 12'(4095 - $urandom_range(0, 7));
      default: x = 12'($urandom_range(0, 4095));
    endcase
    case ($urandom_range(0, 5))
      0, 1, 2: top = int'($urandom_range(0, 80)) - 20;
      3:       top = int'($urandom_range(0, 600)) - 40;
      4:       top = int'($urandom_range(0, 65535)) - 32768;
      default: top = $urandom_range(0, 1) ? -32768 : 32767;
    endcase
    case ($urandom_range(0, 4))
      0:       bot = top + int'($urandom_range(0, 4)) - 2;
      4:       bot = int'($urandom_range(0, 65535)) - 32768;
      default: bot = top + int'($urandom_range(1, 520));
    endcase
    return setup_req(x, 16'(top), 16'(bot), 2'($urandom), 16'($urandom),
                     1'($urandom), 1'($urandom));
  endfunction

  function automatic int pick_rows();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 4) return SCREEN_ROWS + $urandom_range(0, 2);
    if (roll < 9) return 0;
    return $urandom_range(1, 80);
  endfunction

  task automatic run_column(input int n);
    send_item(random_setup());
    repeat (n) send_item(row_req());
  endtask

  task automatic test_reset_defaults();
    send_item(row_req());
    send_item(setup_req(12'd4095, 16'sh8000, 16'sh7fff, SIDE_X, 16'hffff, 1'b1, 1'b0));
    repeat (2) send_item(row_req());
    send_item(setup_req(12'd0, 16'sd0, 16'sd1, SIDE_Y, 16'h0000, 1'b0, 1'b1));
    repeat (3) send_item(row_req());
    send_item(setup_req(12'd7, 16'sd5, 16'sd1, 2'd3, 16'h8000, 1'b1, 1'b1));
    repeat (3) send_item(row_req());
  endtask

  task automatic test_degenerate_setup();
    apply_settings('{ceil_rgb: 24'hffffff, floor_rgb: 24'h000000, tex_w: 13'd0,
                     tex_h: 13'd0, img_w: 13'd1});
    send_item(setup_req(12'd2, 16'sd0, 16'sd4, 2'd2, 16'h8000, 1'b1, 1'b1));
    send_item(row_req());
    send_item(setup_req(12'd0, -16'sd1, 16'sd3, SIDE_X, 16'h1234, 1'b1, 1'b0));
    repeat (2) send_item(row_req());
  endtask

  task automatic test_random_columns(input look_t look, input int quota, input bit full_first);
    int start;
    int rows;
    apply_settings(look);
    start = sent;
    if (full_first) run_column(SCREEN_ROWS + 1);
    while (sent - start < quota) begin
      rows = pick_rows();
      if (rows > quota - (sent - start) - 1) rows = quota - (sent - start) - 1;
      run_column(rows);
    end
  endtask

  task automatic test_receiver_hold();
    calm         = 1'b1;
    hold_request = 1'b1;
    run_column(80);
    calm         = 1'b0;
  endtask

  task automatic test_sender_pause();
    run_column($urandom_range(20, 40));
    drain(0);
    run_column($urandom_range(20, 40));
  endtask

  always begin
    @(posedge clk);
    rx_cycles++;
    if (rx_cycles % 200 == 0) rx_mode = $urandom_range(0, 2);
    if (hold_request) begin
      hold_request = 1'b0;
      out_ready <= 1'b0;
      repeat (HOLD_CYCLES) @(posedge clk);
      out_ready <= 1'b1;
    end else begin
      rx_gap = burst_len(rx_mode);
      if (rx_gap > 0) begin
        out_ready <= 1'b0;
        repeat (rx_gap) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (rows_due.size() == 0) begin
        fails++;
        if (fails <= 10) $display("result with none due: %s", describe(out_item));
      end else begin
        want = rows_due.pop_front();
        checked++;
        kind_seen[out_item.kind]++;
        if (out_item.last) last_seen++;
        if (out_item.row !== want.row || out_item.kind !== want.kind ||
            out_item.texture_select !== want.texture_select ||
            out_item.pixel_index !== want.pixel_index ||
            out_item.texel_index !== want.texel_index ||
            out_item.color !== want.color || out_item.last !== want.last) begin
          fails++;
          if (fails <= 10)
            $display("mismatch: expected %s, got %s", describe(want), describe(out_item));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
      $display("textured_column_span_generator regression: fail");
      $finish;
    end
  end

  initial begin
    look_t typical;
    look_t widest;
    look_t narrowest;
    look_t scrambled;
    look_t pow2;
    typical   = '{ceil_rgb: 24'($urandom), floor_rgb: 24'($urandom), tex_w: 13'd64,
                  tex_h: 13'd64, img_w: 13'd640};
    widest    = '{ceil_rgb: 24'h000000, floor_rgb: 24'hffffff, tex_w: 13'h1fff,
                  tex_h: 13'h1fff, img_w: 13'h1fff};
    narrowest = '{ceil_rgb: 24'($urandom), floor_rgb: 24'($urandom), tex_w: 13'd1,
                  tex_h: 13'd2, img_w: 13'd1};
    scrambled = '{ceil_rgb: 24'($urandom), floor_rgb: 24'($urandom), tex_w: 13'($urandom),
                  tex_h: 13'($urandom), img_w: 13'($urandom)};
    pow2      = '{ceil_rgb: 24'($urandom), floor_rgb: 24'($urandom), tex_w: 13'd4096,
                  tex_h: 13'd4096, img_w: 13'd4096};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_degenerate_setup();
    test_random_columns(typical, 500, 1'b1);
    test_receiver_hold();
    test_random_columns(widest, 180, 1'b0);
    test_sender_pause();
    test_random_columns(narrowest, 180, 1'b0);
    test_random_columns(scrambled, 180, 1'b0);
    calm = 1'b1;
    test_random_columns(pow2, 220, 1'b0);
    drain(SETTLE_CYCLES);
    $display("requests %0d (%0d column setups, %0d rows with no column), results %0d",
             sent + ignored, setups, ignored, checked);
    $display("ceiling %0d, wall %0d, floor %0d, no write %0d, final rows %0d, failures %0d",
             kind_seen[KIND_CEILING], kind_seen[KIND_WALL], kind_seen[KIND_FLOOR],
             kind_seen[KIND_NONE], last_seen, fails);
    if (fails == 0)
      $display("textured_column_span_generator regression: pass");
    else
      $display("textured_column_span_generator regression: fail");
    $finish;
  end

endmodule
